>>> sv/gss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gss_pkg
// Types, register codes and the micro-program of the GJK simplex step unit.
// ----------------------------------------------------------------------------
package gss_pkg;

    localparam int VAL_W   = 54;
    localparam int VEC_W   = 3 * VAL_W;
    localparam int SPLIT_W = 27;
    localparam int OPA_W   = SPLIT_W + 1;
    localparam int OPB_W   = 18;
    localparam int PROD_W  = OPA_W + OPB_W;
    localparam int ACC_W   = 76;
    localparam int DIR_W   = 52;
    localparam int PC_W    = 6;
    localparam int RADR_W  = 4;
    localparam int RDEPTH  = 16;

    // verdict codes
    localparam logic [1:0] V_CONT = 2'd0;
    localparam logic [1:0] V_SEP  = 2'd1;
    localparam logic [1:0] V_HIT  = 2'd2;

    // vector register codes
    localparam logic [3:0] R_ZERO = 4'd0;
    localparam logic [3:0] R_PIN  = 4'd1;
    localparam logic [3:0] R_P0   = 4'd2;
    localparam logic [3:0] R_P1   = 4'd3;
    localparam logic [3:0] R_P2   = 4'd4;
    localparam logic [3:0] R_P3   = 4'd5;
    localparam logic [3:0] R_AB   = 4'd6;
    localparam logic [3:0] R_AC   = 4'd7;
    localparam logic [3:0] R_AD   = 4'd8;
    localparam logic [3:0] R_AO   = 4'd9;
    localparam logic [3:0] R_ABC  = 4'd10;
    localparam logic [3:0] R_ACD  = 4'd11;
    localparam logic [3:0] R_ADB  = 4'd12;
    localparam logic [3:0] R_T    = 4'd13;
    localparam logic [3:0] R_DIR  = 4'd14;
    localparam logic [3:0] R_TMP  = 4'd15;

    // micro-op codes
    localparam logic [2:0] OP_SUB   = 3'd0;
    localparam logic [2:0] OP_CROSS = 3'd1;
    localparam logic [2:0] OP_BRP   = 3'd2;
    localparam logic [2:0] OP_JMP   = 3'd3;
    localparam logic [2:0] OP_DONE  = 3'd4;
    localparam logic [2:0] OP_SEP   = 3'd5;
    localparam logic [2:0] OP_DISP  = 3'd6;

    // program entry points
    localparam logic [PC_W-1:0] PC_START = 6'd0;
    localparam logic [PC_W-1:0] PC_SEP   = 6'd3;
    localparam logic [PC_W-1:0] PC_CONT  = 6'd4;
    localparam logic [PC_W-1:0] PC_LINE  = 6'd11;
    localparam logic [PC_W-1:0] PC_TRI   = 6'd19;
    localparam logic [PC_W-1:0] PC_TET   = 6'd43;

    typedef struct packed {
        logic [2:0]      op;
        logic [3:0]      a;
        logic [3:0]      b;
        logic [3:0]      d;
        logic            neg;
        logic [PC_W-1:0] tgt;
        logic [1:0]      vd;
        logic [2:0]      cnt;
    } instr_t;

    typedef struct packed {
        logic issue;
        logic first;
        logic sub;
        logic hi;
    } mac_ctl_t;

    function automatic instr_t ins(
        input logic [2:0]      op,
        input logic [3:0]      a,
        input logic [3:0]      b,
        input logic [3:0]      d,
        input logic            neg,
        input logic [PC_W-1:0] tgt,
        input logic [1:0]      vd,
        input logic [2:0]      cnt
    );
        instr_t r;
        r.op  = op;
        r.a   = a;
        r.b   = b;
        r.d   = d;
        r.neg = neg;
        r.tgt = tgt;
        r.vd  = vd;
        r.cnt = cnt;
        return r;
    endfunction

    function automatic instr_t mov(input logic [3:0] d, input logic [3:0] s);
        return ins(OP_SUB, s, R_ZERO, d, 1'b0, PC_START, V_CONT, 3'd0);
    endfunction

    function automatic instr_t sub(input logic [3:0] d, input logic [3:0] a,
                                   input logic [3:0] b);
        return ins(OP_SUB, a, b, d, 1'b0, PC_START, V_CONT, 3'd0);
    endfunction

    function automatic instr_t crs(input logic [3:0] d, input logic [3:0] a,
                                   input logic [3:0] b, input logic neg);
        return ins(OP_CROSS, a, b, d, neg, PC_START, V_CONT, 3'd0);
    endfunction

    function automatic instr_t brp(input logic [3:0] a, input logic [3:0] b,
                                   input logic [PC_W-1:0] tgt);
        return ins(OP_BRP, a, b, R_ZERO, 1'b0, tgt, V_CONT, 3'd0);
    endfunction

    function automatic instr_t jmp(input logic [PC_W-1:0] tgt);
        return ins(OP_JMP, R_ZERO, R_ZERO, R_ZERO, 1'b0, tgt, V_CONT, 3'd0);
    endfunction

    function automatic instr_t done(input logic [1:0] vd, input logic [2:0] cnt);
        return ins(OP_DONE, R_DIR, R_ZERO, R_ZERO, 1'b0, PC_START, vd, cnt);
    endfunction

    function automatic instr_t prog(input logic [PC_W-1:0] pc);
        instr_t r;
        unique case (pc)
            // start of a query
            6'd0:  r = mov(R_P0, R_PIN);
            6'd1:  r = sub(R_DIR, R_ZERO, R_PIN);
            6'd2:  r = done(V_CONT, 3'd1);
            6'd3:  r = ins(OP_SEP, R_DIR, R_ZERO, R_ZERO, 1'b0, PC_START, V_SEP, 3'd0);
            // continue: test, then insert at the front
            6'd4:  r = brp(R_DIR, R_PIN, 6'd6);
            6'd5:  r = ins(OP_SEP, R_DIR, R_ZERO, R_ZERO, 1'b0, PC_START, V_SEP, 3'd0);
            6'd6:  r = mov(R_P3, R_P2);
            6'd7:  r = mov(R_P2, R_P1);
            6'd8:  r = mov(R_P1, R_P0);
            6'd9:  r = mov(R_P0, R_PIN);
            6'd10: r = ins(OP_DISP, R_ZERO, R_ZERO, R_ZERO, 1'b0, PC_START, V_CONT, 3'd0);
            // line
            6'd11: r = sub(R_AB, R_P1, R_P0);
            6'd12: r = sub(R_AO, R_ZERO, R_P0);
            6'd13: r = brp(R_AB, R_AO, 6'd16);
            6'd14: r = mov(R_DIR, R_AO);
            6'd15: r = done(V_CONT, 3'd1);
            6'd16: r = crs(R_T, R_AB, R_AO, 1'b0);
            6'd17: r = crs(R_DIR, R_T, R_AB, 1'b0);
            6'd18: r = done(V_CONT, 3'd2);
            // triangle
            6'd19: r = sub(R_AB, R_P1, R_P0);
            6'd20: r = sub(R_AC, R_P2, R_P0);
            6'd21: r = sub(R_AO, R_ZERO, R_P0);
            6'd22: r = crs(R_ABC, R_AB, R_AC, 1'b0);
            6'd23: r = crs(R_T, R_ABC, R_AC, 1'b0);
            6'd24: r = brp(R_T, R_AO, 6'd26);
            6'd25: r = jmp(6'd32);
            6'd26: r = brp(R_AC, R_AO, 6'd28);
            6'd27: r = jmp(PC_LINE);
            6'd28: r = mov(R_P1, R_P2);
            6'd29: r = crs(R_T, R_AC, R_AO, 1'b0);
            6'd30: r = crs(R_DIR, R_T, R_AC, 1'b0);
            6'd31: r = done(V_CONT, 3'd2);
            6'd32: r = crs(R_T, R_ABC, R_AB, 1'b1);
            6'd33: r = brp(R_T, R_AO, PC_LINE);
            6'd34: r = brp(R_ABC, R_AO, 6'd36);
            6'd35: r = jmp(6'd38);
            6'd36: r = mov(R_DIR, R_ABC);
            6'd37: r = done(V_CONT, 3'd3);
            6'd38: r = mov(R_TMP, R_P1);
            6'd39: r = mov(R_P1, R_P2);
            6'd40: r = mov(R_P2, R_TMP);
            6'd41: r = sub(R_DIR, R_ZERO, R_ABC);
            6'd42: r = done(V_CONT, 3'd3);
            // tetrahedron
            6'd43: r = sub(R_AB, R_P1, R_P0);
            6'd44: r = sub(R_AC, R_P2, R_P0);
            6'd45: r = sub(R_AD, R_P3, R_P0);
            6'd46: r = sub(R_AO, R_ZERO, R_P0);
            6'd47: r = crs(R_ABC, R_AB, R_AC, 1'b0);
            6'd48: r = crs(R_ACD, R_AC, R_AD, 1'b0);
            6'd49: r = crs(R_ADB, R_AD, R_AB, 1'b0);
            6'd50: r = brp(R_ABC, R_AO, PC_TRI);
            6'd51: r = brp(R_ACD, R_AO, 6'd54);
            6'd52: r = brp(R_ADB, R_AO, 6'd57);
            6'd53: r = done(V_HIT, 3'd4);
            6'd54: r = mov(R_P1, R_P2);
            6'd55: r = mov(R_P2, R_P3);
            6'd56: r = jmp(PC_TRI);
            6'd57: r = mov(R_TMP, R_P1);
            6'd58: r = mov(R_P1, R_P3);
            6'd59: r = mov(R_P2, R_TMP);
            6'd60: r = jmp(PC_TRI);
            default: r = ins(OP_SEP, R_DIR, R_ZERO, R_ZERO, 1'b0, PC_START, V_SEP, 3'd0);
        endcase
        return r;
    endfunction

endpackage

>>> sv/gss_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gss_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module gss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/gss_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gss_mac
// Shared multiply-accumulate unit: one 28x18 signed product per cycle while issue is high,
// registered, then added to or subtracted from a wide accumulator.
// ----------------------------------------------------------------------------
module gss_mac (
    input  logic                              clk,
    input  logic                              rst_n,
    input  gss_pkg::mac_ctl_t                 ctl,
    input  logic signed [gss_pkg::VAL_W-1:0]  a_el,
    input  logic signed [gss_pkg::OPB_W-1:0]  b_el,
    output logic signed [gss_pkg::ACC_W-1:0]  acc
);

    logic signed [gss_pkg::OPA_W-1:0]  a_part;
    logic signed [gss_pkg::PROD_W-1:0] prod_next;
    logic signed [gss_pkg::PROD_W-1:0] prod_reg;
    gss_pkg::mac_ctl_t                 ctl_reg;
    logic signed [gss_pkg::ACC_W-1:0]  term;
    logic signed [gss_pkg::ACC_W-1:0]  base;
    logic signed [gss_pkg::ACC_W-1:0]  acc_next;
    logic signed [gss_pkg::ACC_W-1:0]  acc_reg;

    always_comb
    begin
        if (ctl.hi)
        begin
            a_part = {a_el[gss_pkg::VAL_W-1], a_el[gss_pkg::VAL_W-1:gss_pkg::SPLIT_W]};
        end
        else
        begin
            a_part = {1'b0, a_el[gss_pkg::SPLIT_W-1:0]};
        end
        prod_next = a_part * b_el;
    end

    always_comb
    begin
        term = gss_pkg::ACC_W'(prod_reg);
        if (ctl_reg.hi)
        begin
            term = term <<< gss_pkg::SPLIT_W;
        end
        base     = ctl_reg.first ? '0 : acc_reg;
        acc_next = ctl_reg.sub ? (base - term) : (base + term);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.issue)
        begin
            prod_reg <= prod_next;
        end
        if (ctl_reg.issue)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

>>> sv/gjk_simplex_step_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gjk_simplex_step_unit
// GJK 3D intersection step: takes one Minkowski support point per request,
// updates the simplex and returns a verdict and the next search direction.
// ----------------------------------------------------------------------------
// usage
//   input channel  : in_valid / in_stall with req_type, support_x/y/z
//                    (req_type 0 opens a query, 1 continues it)
//   output channel : out_valid / out_stall with verdict, next_dir_x/y/z,
//                    simplex_count; exactly one result per request
//   throughput     : one request at a time; in_stall is high from acceptance
//                    until the result is loaded into the output register
//   timing is set by the micro-program; dot and cross products run on the
//   one 28x18 multiplier
//   reset          : no query is running; a continue request then answers
//                    separated with a count of zero
//   output stall   : the result register holds; the next request may be
//                    accepted meanwhile but its result waits for the slot
// ----------------------------------------------------------------------------
module gjk_simplex_step_unit #(
    parameter int COORD_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       req_type,
    input  logic signed [15:0]         support_x,
    input  logic signed [15:0]         support_y,
    input  logic signed [15:0]         support_z,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [1:0]                 verdict,
    output logic signed [gss_pkg::DIR_W-1:0] next_dir_x,
    output logic signed [gss_pkg::DIR_W-1:0] next_dir_y,
    output logic signed [gss_pkg::DIR_W-1:0] next_dir_z,
    output logic [2:0]                 simplex_count
);

    localparam int VW = gss_pkg::VAL_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FETCH = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;
    localparam logic [1:0] S_MUL   = 2'd3;

    logic [1:0]                  state_reg, state_next;
    logic [gss_pkg::PC_W-1:0]    pc_reg, pc_next;
    logic [2:0]                  size_reg, size_next;
    logic [2:0]                  tc_reg, tc_next;
    logic [1:0]                  cc_reg, cc_next;
    logic [VW-1:0]               res_reg [2];
    logic [VW-1:0]               res_next [2];
    gss_pkg::instr_t             cur;

    logic                        out_valid_reg, out_valid_next;
    logic [1:0]                  verdict_reg, verdict_next;
    logic [gss_pkg::DIR_W-1:0]   dir_reg [3];
    logic [gss_pkg::DIR_W-1:0]   dir_next [3];
    logic [2:0]                  count_reg, count_next;

    logic                        wr_en;
    logic [gss_pkg::RADR_W-1:0]  wr_addr;
    logic [gss_pkg::VEC_W-1:0]   wr_data;
    logic [gss_pkg::VEC_W-1:0]   rd_a_raw, rd_b_raw;
    logic [gss_pkg::VEC_W-1:0]   vec_a, vec_b, vec_diff;
    logic [gss_pkg::VEC_W-1:0]   pin_vec;

    gss_pkg::mac_ctl_t           mac_ctl;
    logic [1:0]                  ea, eb;
    logic signed [VW-1:0]        a_el;
    logic signed [gss_pkg::OPB_W-1:0] b_el;
    logic signed [gss_pkg::ACC_W-1:0] acc;
    logic                        is_cross;
    logic                        acc_pos;
    logic                        in_acc;
    logic                        out_free;
    logic [2:0]                  grown;

    assign cur      = gss_pkg::prog(pc_reg);
    assign in_acc   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !(out_valid_reg && out_stall);
    assign is_cross = (cur.op == gss_pkg::OP_CROSS);
    assign acc_pos  = !acc[gss_pkg::ACC_W-1] && (acc != '0);
    assign grown    = (size_reg == 3'd4) ? 3'd4 : (size_reg + 3'd1);

    assign pin_vec = {
        {{(VW-COORD_BITS){support_z[COORD_BITS-1]}}, support_z[COORD_BITS-1:0]},
        {{(VW-COORD_BITS){support_y[COORD_BITS-1]}}, support_y[COORD_BITS-1:0]},
        {{(VW-COORD_BITS){support_x[COORD_BITS-1]}}, support_x[COORD_BITS-1:0]}
    };

    gss_ram #(
        .WIDTH (gss_pkg::VEC_W),
        .DEPTH (gss_pkg::RDEPTH)
    ) u_ram_a (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (cur.a),
        .rd_data (rd_a_raw)
    );

    gss_ram #(
        .WIDTH (gss_pkg::VEC_W),
        .DEPTH (gss_pkg::RDEPTH)
    ) u_ram_b (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (cur.b),
        .rd_data (rd_b_raw)
    );

    assign vec_a = (cur.a == gss_pkg::R_ZERO) ? '0 : rd_a_raw;
    assign vec_b = (cur.b == gss_pkg::R_ZERO) ? '0 : rd_b_raw;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            vec_diff[i*VW +: VW] = vec_a[i*VW +: VW] - vec_b[i*VW +: VW];
        end
    end

    // operand element selection for the shared multiplier
    always_comb
    begin
        logic [1:0] j;
        logic [1:0] k;
        j = (cc_reg == 2'd2) ? 2'd0 : (cc_reg + 2'd1);
        k = (j == 2'd2) ? 2'd0 : (j + 2'd1);
        if (is_cross)
        begin
            ea = tc_reg[1] ? k : j;
            eb = tc_reg[1] ? j : k;
        end
        else
        begin
            ea = tc_reg[2:1];
            eb = tc_reg[2:1];
        end
        mac_ctl.first = (tc_reg == 3'd0);
        mac_ctl.hi    = tc_reg[0];
        mac_ctl.sub   = is_cross && (tc_reg[1] ^ cur.neg);
        mac_ctl.issue = (state_reg == S_MUL) &&
                        (is_cross ? (tc_reg < 3'd4) : (tc_reg < 3'd6));
    end

    always_comb
    begin
        a_el = '0;
        b_el = '0;
        case (ea)
            2'd0:    a_el = vec_a[0 +: VW];
            2'd1:    a_el = vec_a[VW +: VW];
            default: a_el = vec_a[2*VW +: VW];
        endcase
        case (eb)
            2'd0:    b_el = vec_b[0 +: gss_pkg::OPB_W];
            2'd1:    b_el = vec_b[VW +: gss_pkg::OPB_W];
            default: b_el = vec_b[2*VW +: gss_pkg::OPB_W];
        endcase
    end

    gss_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .a_el  (a_el),
        .b_el  (b_el),
        .acc   (acc)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        size_next      = size_reg;
        tc_next        = tc_reg;
        cc_next        = cc_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && out_stall;
        verdict_next   = verdict_reg;
        dir_next       = dir_reg;
        count_next     = count_reg;
        wr_en          = 1'b0;
        wr_addr        = cur.d;
        wr_data        = vec_diff;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = gss_pkg::R_PIN;
                    wr_data    = pin_vec;
                    state_next = S_FETCH;
                    if (!req_type)
                    begin
                        pc_next = gss_pkg::PC_START;
                    end
                    else if (size_reg == 3'd0)
                    begin
                        pc_next = gss_pkg::PC_SEP;
                    end
                    else
                    begin
                        pc_next = gss_pkg::PC_CONT;
                    end
                end
            end
            S_FETCH:
            begin
                state_next = S_EXEC;
                tc_next    = '0;
                cc_next    = '0;
            end
            S_EXEC:
            begin
                unique case (cur.op) inside
                    gss_pkg::OP_SUB:
                    begin
                        wr_en      = 1'b1;
                        pc_next    = pc_reg + 1'b1;
                        state_next = S_FETCH;
                    end
                    gss_pkg::OP_CROSS, gss_pkg::OP_BRP:
                    begin
                        state_next = S_MUL;
                    end
                    gss_pkg::OP_JMP:
                    begin
                        pc_next    = cur.tgt;
                        state_next = S_FETCH;
                    end
                    gss_pkg::OP_DISP:
                    begin
                        size_next  = grown;
                        state_next = S_FETCH;
                        if (grown == 3'd2)
                        begin
                            pc_next = gss_pkg::PC_LINE;
                        end
                        else if (grown == 3'd3)
                        begin
                            pc_next = gss_pkg::PC_TRI;
                        end
                        else
                        begin
                            pc_next = gss_pkg::PC_TET;
                        end
                    end
                    default:
                    begin
                        // result out, query ends unless the verdict is continue
                        if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            verdict_next   = cur.vd;
                            count_next     = (cur.op == gss_pkg::OP_SEP) ? size_reg : cur.cnt;
                            for (int i = 0; i < 3; i++)
                            begin
                                dir_next[i] = (cur.vd == gss_pkg::V_CONT) ?
                                              vec_a[i*VW +: gss_pkg::DIR_W] : '0;
                            end
                            size_next  = (cur.vd == gss_pkg::V_CONT) ? cur.cnt : 3'd0;
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end
            default:
            begin
                tc_next = tc_reg + 3'd1;
                if (is_cross && (tc_reg == 3'd5))
                begin
                    tc_next = '0;
                    if (cc_reg == 2'd2)
                    begin
                        wr_en      = 1'b1;
                        wr_data    = {acc[VW-1:0], res_reg[1], res_reg[0]};
                        pc_next    = pc_reg + 1'b1;
                        state_next = S_FETCH;
                    end
                    else
                    begin
                        res_next[cc_reg[0]] = acc[VW-1:0];
                        cc_next             = cc_reg + 2'd1;
                    end
                end
                else if (!is_cross && (tc_reg == 3'd7))
                begin
                    pc_next    = acc_pos ? cur.tgt : (pc_reg + 1'b1);
                    state_next = S_FETCH;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= gss_pkg::PC_START;
            size_reg      <= 3'd0;
            tc_reg        <= '0;
            cc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            size_reg      <= size_next;
            tc_reg        <= tc_next;
            cc_reg        <= cc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg     <= res_next;
        verdict_reg <= verdict_next;
        dir_reg     <= dir_next;
        count_reg   <= count_next;
    end

    assign out_valid     = out_valid_reg;
    assign verdict       = verdict_reg;
    assign next_dir_x    = dir_reg[0];
    assign next_dir_y    = dir_reg[1];
    assign next_dir_z    = dir_reg[2];
    assign simplex_count = count_reg;

    // checks
    a_size_range: assert property (@(posedge clk) disable iff (!rst_n)
        size_reg <= 3'd4)
        else $error("simplex size out of range");

    a_accept_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg == S_FETCH))
        else $error("request accepted without starting the program");

    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (verdict_reg != 2'd3))
        else $error("illegal verdict code");

    a_end_dir_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (verdict_reg != gss_pkg::V_CONT)) |->
        ((dir_reg[0] == '0) && (dir_reg[1] == '0) && (dir_reg[2] == '0)))
        else $error("direction not cleared at end of query");

    a_end_size_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(out_valid_reg) && (verdict_reg != gss_pkg::V_CONT)) |->
        (size_reg == 3'd0))
        else $error("query not closed after final verdict");

endmodule
